// ===== sv/tfda_pkg.sv =====
package tfda_pkg;

    localparam int WindowMax = 64;
    localparam int StageMax  = 64;
    localparam int WIDX_W    = $clog2(WindowMax);
    localparam int SIDX_W    = $clog2(StageMax);
    localparam int WCNT_W    = $clog2(WindowMax + 1);
    localparam int SCNT_W    = $clog2(StageMax + 1);
    localparam int SUM_W     = 16 + WCNT_W;

    localparam logic [7:0] SYNC_A = 8'h5A;
    localparam logic [7:0] SYNC_B = 8'h03;

    localparam logic [1:0] ST_GOOD     = 2'd0;
    localparam logic [1:0] ST_CHECKSUM = 2'd1;
    localparam logic [1:0] ST_OVERSIZE = 2'd2;

    localparam logic [1:0] REG_WINDOW_LEN = 2'd0;
    localparam logic [1:0] REG_OFFSET     = 2'd1;
    localparam logic [1:0] REG_GAIN       = 2'd2;

    // Controller commands to datapath
    typedef struct packed {
        logic       stage_low;   // capture low byte
        logic       stage_tof;   // write staged tof
        logic       stage_peak;  // write staged peak, bump count
        logic       commit_step; // push one staged pair into window
        logic       sum_clear;   // clear window sum walk
        logic       sum_step;    // add one window entry
        logic       div_start;   // start dividers
        logic       out_load;    // compute distance and load output
        logic [1:0] status;
    } tfda_cmd_t;

    typedef struct packed {
        logic              commit_done;
        logic              sum_done;
        logic              div_done;
        logic              mul_done;
    } tfda_sts_t;

endpackage

// ===== sv/tfda_datapath.sv =====
module tfda_datapath
    import tfda_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  tfda_cmd_t         cmd,
    output tfda_sts_t         sts,
    input  logic [7:0]        rx_byte,
    input  logic              clear_window,
    input  logic [6:0]        window_len,
    input  logic [15:0]       range_offset,
    input  logic [15:0]       distance_gain,
    output logic [23:0]       distance,
    output logic [15:0]       avg_peak,
    output logic [1:0]        frame_status,
    output logic [6:0]        window_count
);

    logic [15:0] staged_tof  [StageMax];
    logic [15:0] staged_peak [StageMax];
    logic [15:0] window_tof  [WindowMax];
    logic [15:0] window_peak [WindowMax];

    logic [7:0]        low_reg;
    logic [SCNT_W-1:0] staged_count_reg;
    logic [SCNT_W-1:0] commit_idx_reg;
    logic [WIDX_W-1:0] head_reg;
    logic [WCNT_W-1:0] fill_reg;
    logic [WCNT_W-1:0] sum_idx_reg;
    logic [SUM_W-1:0]  st_reg, sp_reg;
    logic [15:0]       rd_tof_reg, rd_peak_reg;
    logic              rd_valid_reg;
    logic [WCNT_W-1:0] cap;
    logic [WCNT_W-1:0] head_ext;

    // Saturate window length into 1..WindowMax
    always_comb begin
        if (window_len == 7'd0) begin
            cap = WCNT_W'(1);
        end else if (32'(window_len) > WindowMax) begin
            cap = WCNT_W'(WindowMax);
        end else begin
            cap = WCNT_W'(window_len);
        end
        head_ext = WCNT_W'(head_reg);
    end

    // Stage pairs from the payload
    always_ff @(posedge aclk) begin
        if (cmd.stage_low) begin
            low_reg <= rx_byte;
        end
        if (cmd.stage_tof && (32'(staged_count_reg) < StageMax)) begin
            staged_tof[staged_count_reg[SIDX_W-1:0]] <= {rx_byte, low_reg};
        end
        if (cmd.stage_peak && (32'(staged_count_reg) < StageMax)) begin
            staged_peak[staged_count_reg[SIDX_W-1:0]] <= {rx_byte, low_reg};
        end
    end

    // Staged reads for the commit walk
    logic [15:0] cm_tof_reg, cm_peak_reg;
    logic        cm_valid_reg;
    always_ff @(posedge aclk) begin
        cm_tof_reg  <= staged_tof[commit_idx_reg[SIDX_W-1:0]];
        cm_peak_reg <= staged_peak[commit_idx_reg[SIDX_W-1:0]];
    end

    logic [WIDX_W-1:0] wr_head;
    always_comb begin
        wr_head = (head_ext >= cap) ? '0 : head_reg;
    end

    // Window writes from registered staged data
    always_ff @(posedge aclk) begin
        if (cm_valid_reg) begin
            window_tof[wr_head]  <= cm_tof_reg;
            window_peak[wr_head] <= cm_peak_reg;
        end
    end

    // Commit walk and window control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            staged_count_reg <= '0;
            commit_idx_reg   <= '0;
            cm_valid_reg     <= 1'b0;
            head_reg         <= '0;
            fill_reg         <= '0;
        end else begin
            cm_valid_reg <= 1'b0;
            if (cmd.stage_peak && (32'(staged_count_reg) < StageMax)) begin
                staged_count_reg <= staged_count_reg + 1'b1;
            end
            if (cmd.commit_step && !cm_valid_reg && commit_idx_reg < staged_count_reg) begin
                cm_valid_reg   <= 1'b1;
                commit_idx_reg <= commit_idx_reg + 1'b1;
            end
            if (cm_valid_reg) begin
                if (WCNT_W'(wr_head) + 1'b1 >= cap) begin
                    head_reg <= '0;
                end else begin
                    head_reg <= wr_head + 1'b1;
                end
                if (fill_reg < cap) begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            if (cmd.out_load) begin
                staged_count_reg <= '0;
                commit_idx_reg   <= '0;
            end
            if (clear_window) begin
                head_reg <= '0;
                fill_reg <= '0;
            end
        end
    end

    assign sts.commit_done = !cm_valid_reg && (commit_idx_reg >= staged_count_reg);

    // Window sum walk: one entry per cycle through a registered read
    always_ff @(posedge aclk) begin
        rd_tof_reg  <= window_tof[sum_idx_reg[WIDX_W-1:0]];
        rd_peak_reg <= window_peak[sum_idx_reg[WIDX_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_idx_reg  <= '0;
            rd_valid_reg <= 1'b0;
            st_reg       <= '0;
            sp_reg       <= '0;
        end else begin
            rd_valid_reg <= 1'b0;
            if (cmd.sum_clear) begin
                sum_idx_reg <= '0;
                st_reg      <= '0;
                sp_reg      <= '0;
            end else if (cmd.sum_step) begin
                if (rd_valid_reg) begin
                    st_reg <= st_reg + SUM_W'(rd_tof_reg);
                    sp_reg <= sp_reg + SUM_W'(rd_peak_reg);
                end
                if (sum_idx_reg < fill_reg) begin
                    sum_idx_reg  <= sum_idx_reg + 1'b1;
                    rd_valid_reg <= 1'b1;
                end
            end
        end
    end

    assign sts.sum_done = !rd_valid_reg && (sum_idx_reg >= fill_reg);

    // Restoring dividers, one quotient bit per cycle
    logic [SUM_W-1:0]  qt_reg, qp_reg;
    logic [WCNT_W:0]   rt_reg, rp_reg;
    logic [SUM_W-1:0]  nt_reg, np_reg;
    logic [$clog2(SUM_W+1)-1:0] dcnt_reg;
    logic              dbusy_reg;
    logic [WCNT_W:0]   rt_sh, rp_sh, dv;

    always_comb begin
        dv    = {1'b0, fill_reg};
        rt_sh = {rt_reg[WCNT_W-1:0], nt_reg[SUM_W-1]};
        rp_sh = {rp_reg[WCNT_W-1:0], np_reg[SUM_W-1]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dbusy_reg <= 1'b0;
            dcnt_reg  <= '0;
        end else if (cmd.div_start) begin
            dbusy_reg <= 1'b1;
            dcnt_reg  <= '0;
            nt_reg    <= st_reg;
            np_reg    <= sp_reg;
            rt_reg    <= '0;
            rp_reg    <= '0;
            qt_reg    <= '0;
            qp_reg    <= '0;
        end else if (dbusy_reg) begin
            nt_reg <= nt_reg << 1;
            np_reg <= np_reg << 1;
            if (rt_sh >= dv) begin
                rt_reg <= rt_sh - dv;
                qt_reg <= {qt_reg[SUM_W-2:0], 1'b1};
            end else begin
                rt_reg <= rt_sh;
                qt_reg <= {qt_reg[SUM_W-2:0], 1'b0};
            end
            if (rp_sh >= dv) begin
                rp_reg <= rp_sh - dv;
                qp_reg <= {qp_reg[SUM_W-2:0], 1'b1};
            end else begin
                rp_reg <= rp_sh;
                qp_reg <= {qp_reg[SUM_W-2:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg + 1'b1;
            if (32'(dcnt_reg) == SUM_W - 1) begin
                dbusy_reg <= 1'b0;
            end
        end
    end

    logic ddone_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ddone_reg <= 1'b0;
        end else begin
            ddone_reg <= dbusy_reg && (32'(dcnt_reg) == SUM_W - 1);
        end
    end
    assign sts.div_done = ddone_reg;

    // Offset correction and gain multiply, registered
    logic [15:0] avg_tof, avg_pk, diff_reg, pk_reg;
    logic        mul_go_reg;
    logic [31:0] prod;
    always_comb begin
        avg_tof = (fill_reg == '0) ? 16'd0 : qt_reg[15:0];
        avg_pk  = (fill_reg == '0) ? 16'd0 : qp_reg[15:0];
        prod    = diff_reg * distance_gain;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_go_reg <= 1'b0;
        end else begin
            mul_go_reg <= ddone_reg;
        end
        if (ddone_reg) begin
            diff_reg <= (avg_tof > range_offset) ? avg_tof - range_offset : 16'd0;
            pk_reg   <= avg_pk;
        end
    end
    assign sts.mul_done = mul_go_reg;

    // Output register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            distance     <= prod[31:8];
            avg_peak     <= pk_reg;
            frame_status <= cmd.status;
            window_count <= 7'(fill_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (aresetn) begin
            assert (fill_reg <= WCNT_W'(WindowMax))
                else $error("window fill exceeds capacity");
        end
    end

    property p_head_in_range;
        @(posedge aclk) disable iff (!aresetn)
            cm_valid_reg |=> (WCNT_W'(head_reg) < cap || clear_window);
    endproperty
    a_head: assert property (p_head_in_range) else $error("head out of window");

    property p_div_done_pulse;
        @(posedge aclk) disable iff (!aresetn) ddone_reg |=> !ddone_reg;
    endproperty
    a_div: assert property (p_div_done_pulse) else $error("divider done repeated");

    property p_stage_bound;
        @(posedge aclk) disable iff (!aresetn)
            32'(staged_count_reg) <= StageMax;
    endproperty
    a_stage: assert property (p_stage_bound) else $error("staged count overflow");

endmodule

// ===== sv/tfda_ctrl.sv =====
module tfda_ctrl
    import tfda_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output tfda_cmd_t   cmd,
    input  tfda_sts_t   sts
);

    localparam logic [3:0] S_SYNC_A  = 4'd0;
    localparam logic [3:0] S_SYNC_B  = 4'd1;
    localparam logic [3:0] S_LEN_LO  = 4'd2;
    localparam logic [3:0] S_LEN_HI  = 4'd3;
    localparam logic [3:0] S_PAYLOAD = 4'd4;
    localparam logic [3:0] S_CHECK   = 4'd5;
    localparam logic [3:0] S_COMMIT  = 4'd6;
    localparam logic [3:0] S_SUM     = 4'd7;
    localparam logic [3:0] S_DIV     = 4'd8;
    localparam logic [3:0] S_MUL     = 4'd9;
    localparam logic [3:0] S_OUT     = 4'd10;

    logic [3:0]  state_reg, state_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] pos_reg, pos_next;
    logic [7:0]  sum_reg, sum_next;
    logic [1:0]  status_reg, status_next;
    logic        mvalid_reg, mvalid_next;
    logic        accept;
    logic [7:0]  sum_plus;

    assign s_ready  = (state_reg <= S_CHECK) && !(state_reg == S_CHECK && mvalid_reg);
    assign accept   = s_valid && s_ready;
    assign m_valid  = mvalid_reg;
    assign sum_plus = sum_reg + s_rx_byte;

    always_comb begin
        state_next  = state_reg;
        len_next    = len_reg;
        pos_next    = pos_reg;
        sum_next    = sum_reg;
        status_next = status_reg;
        mvalid_next = mvalid_reg && !m_ready;
        cmd         = '0;
        cmd.status  = status_reg;
        case (state_reg)
            S_SYNC_A: begin
                if (accept && s_rx_byte == SYNC_A) begin
                    state_next = S_SYNC_B;
                end
            end
            S_SYNC_B: begin
                if (accept) begin
                    if (s_rx_byte == SYNC_B) begin
                        sum_next   = SYNC_B;
                        state_next = S_LEN_LO;
                    end else if (s_rx_byte != SYNC_A) begin
                        state_next = S_SYNC_A;
                    end
                end
            end
            S_LEN_LO: begin
                if (accept) begin
                    len_next   = {8'd0, s_rx_byte};
                    sum_next   = sum_plus;
                    state_next = S_LEN_HI;
                end
            end
            S_LEN_HI: begin
                if (accept) begin
                    len_next   = {s_rx_byte, len_reg[7:0]};
                    sum_next   = sum_plus;
                    pos_next   = '0;
                    state_next = ({s_rx_byte, len_reg[7:0]} == 16'd0) ? S_CHECK : S_PAYLOAD;
                end
            end
            S_PAYLOAD: begin
                if (accept) begin
                    sum_next = sum_plus;
                    if (pos_reg < {len_reg[15:2], 2'b00}) begin
                        case (pos_reg[1:0])
                            2'd1:    cmd.stage_tof  = 1'b1;
                            2'd3:    cmd.stage_peak = 1'b1;
                            default: cmd.stage_low  = 1'b1;
                        endcase
                    end
                    pos_next = pos_reg + 1'b1;
                    if (pos_reg + 1'b1 >= len_reg) begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (accept) begin
                    if (~sum_reg != s_rx_byte) begin
                        status_next = ST_CHECKSUM;
                        state_next  = S_SUM;
                    end else if (32'(len_reg[15:2]) > StageMax) begin
                        status_next = ST_OVERSIZE;
                        state_next  = S_SUM;
                    end else begin
                        status_next = ST_GOOD;
                        state_next  = S_COMMIT;
                    end
                    cmd.sum_clear = 1'b1;
                end
            end
            S_COMMIT: begin
                cmd.commit_step = 1'b1;
                if (sts.commit_done) begin
                    state_next = S_SUM;
                end
            end
            S_SUM: begin
                cmd.sum_step = 1'b1;
                if (sts.sum_done) begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV: begin
                if (sts.div_done) begin
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                if (sts.mul_done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!mvalid_reg) begin
                    cmd.out_load = 1'b1;
                    mvalid_next  = 1'b1;
                    state_next   = S_SYNC_A;
                end
            end
            default: state_next = S_SYNC_A;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_SYNC_A;
            len_reg    <= '0;
            pos_reg    <= '0;
            sum_reg    <= '0;
            status_reg <= ST_GOOD;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            pos_reg    <= pos_next;
            sum_reg    <= sum_next;
            status_reg <= status_next;
            mvalid_reg <= mvalid_next;
        end
    end

    property p_load_when_free;
        @(posedge aclk) disable iff (!aresetn) cmd.out_load |-> !mvalid_reg;
    endproperty
    a_load: assert property (p_load_when_free) else $error("result overwritten");

    property p_no_accept_busy;
        @(posedge aclk) disable iff (!aresetn) (state_reg > S_CHECK) |-> !s_ready;
    endproperty
    a_busy: assert property (p_no_accept_busy) else $error("byte taken while busy");

    property p_out_to_hunt;
        @(posedge aclk) disable iff (!aresetn) cmd.out_load |=> state_reg == S_SYNC_A;
    endproperty
    a_hunt: assert property (p_out_to_hunt) else $error("no return to hunt");

endmodule

// ===== sv/tof_frame_deframer_averager.sv =====
// Time-of-flight link deframer with sliding-window averaging.
// s_ channel: one link byte per item (s_rx_byte). Frames are 5A 03, LE16
// length, payload, checksum (inverted sum of bytes after 5A). Each group of
// four payload bytes is a TOF/PEAK pair.
// m_ channel: one item per frame, issued after its checksum byte, carrying
// distance, avg_peak, frame_status and window_count.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): 0 window_len (a
// write empties the window), 1 offset, 2 distance_gain; always ready.
// Flow: header and payload bytes are taken back to back. The checksum
// byte starts a post-frame walk: commit of the staged pairs (good frames
// only), window sum, bit-serial divider, offset correction and gain
// multiply, then result load, which raises m_valid. s_ready stays low
// through the walk.
// Reset clears control state and empties the window; stores need no clear.
// A stalled m_ side holds the result; framing continues, but the next
// checksum byte waits until the pending result is taken.
module tof_frame_deframer_averager
    import tfda_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [23:0] m_distance,
    output logic [15:0] m_avg_peak,
    output logic [1:0]  m_frame_status,
    output logic [6:0]  m_window_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    tfda_cmd_t   cmd;
    tfda_sts_t   sts;
    logic [6:0]  wlen_reg;
    logic [15:0] offset_reg, gain_reg;
    logic        cfg_wr, clear_window;

    assign cfg_ready    = 1'b1;
    assign cfg_wr       = cfg_valid && cfg_ready;
    assign clear_window = cfg_wr && (cfg_index == REG_WINDOW_LEN);

    // Hold configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlen_reg   <= 7'd1;
            offset_reg <= 16'd0;
            gain_reg   <= 16'd256;
        end else if (cfg_wr) begin
            case (cfg_index)
                REG_WINDOW_LEN: wlen_reg   <= cfg_data[6:0];
                REG_OFFSET:     offset_reg <= cfg_data;
                REG_GAIN:       gain_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    tfda_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    tfda_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .rx_byte       (s_rx_byte),
        .clear_window  (clear_window),
        .window_len    (wlen_reg),
        .range_offset  (offset_reg),
        .distance_gain (gain_reg),
        .distance      (m_distance),
        .avg_peak      (m_avg_peak),
        .frame_status  (m_frame_status),
        .window_count  (m_window_count)
    );

endmodule

// ===== test/frame_checker.sv =====
`timescale 1ns / 100ps

// Watches the byte, result and register channels, tracks the frame decoder
// and the averaging window, and compares every result with its prediction.
module frame_checker
    import tfda_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [23:0] m_distance,
    input  logic [15:0] m_avg_peak,
    input  logic [1:0]  m_frame_status,
    input  logic [6:0]  m_window_count,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          awaiting
);

    typedef enum logic [2:0] {
        SEEK_A, SEEK_B, LEN_LO, LEN_HI, PAYLOAD, CHECK
    } phase_e;

    typedef struct packed {
        logic [23:0] distance;
        logic [15:0] avg_peak;
        logic [1:0]  status;
        logic [6:0]  count;
    } report_t;

    report_t report_q[$];

    // register copies
    logic [6:0]  win_len;
    logic [15:0] offset;
    logic [15:0] gain;

    // decoder and window state
    phase_e      phase;
    logic [15:0] pos;
    logic [15:0] plen;
    logic [7:0]  csum;
    logic [7:0]  low_hold;
    logic [15:0] stage_tof  [StageMax];
    logic [15:0] stage_peak [StageMax];
    int          stage_cnt;
    logic [15:0] win_tof  [WindowMax];
    logic [15:0] win_peak [WindowMax];
    int          head;
    int          fill;

    function automatic int capacity();
        if (win_len == 0) return 1;
        if (win_len > WindowMax) return WindowMax;
        return int'(win_len);
    endfunction

    task automatic push_pair(input logic [15:0] t, input logic [15:0] p);
        int cap;
        cap = capacity();
        if (head >= cap) head = 0;
        win_tof[head]  = t;
        win_peak[head] = p;
        head = (head + 1) % cap;
        if (fill < cap) fill++;
    endtask

    // Build the result for the current window contents.
    function automatic report_t window_report(input logic [1:0] st);
        report_t r;
        longint  sum_t, sum_p, avg_t, avg_p, range_val;
        sum_t     = 0;
        sum_p     = 0;
        avg_t     = 0;
        avg_p     = 0;
        range_val = 0;
        for (int i = 0; i < fill; i++) begin
            sum_t += win_tof[i];
            sum_p += win_peak[i];
        end
        if (fill != 0) begin
            avg_t = sum_t / fill;
            avg_p = sum_p / fill;
        end
        if (avg_t > offset) range_val = ((avg_t - offset) * gain) >> 8;
        r.distance = range_val[23:0];
        r.avg_peak = avg_p[15:0];
        r.status   = st;
        r.count    = 7'(fill);
        return r;
    endfunction

    // Advance the decoder by one link byte.
    task automatic take_byte(input logic [7:0] b);
        logic [1:0] st;
        case (phase)
            SEEK_A: if (b == SYNC_A) phase = SEEK_B;
            SEEK_B: begin
                if (b == SYNC_B) begin
                    csum  = SYNC_B;
                    phase = LEN_LO;
                end else if (b != SYNC_A) begin
                    phase = SEEK_A;
                end
            end
            LEN_LO: begin
                plen  = {8'h00, b};
                csum  = csum + b;
                phase = LEN_HI;
            end
            LEN_HI: begin
                plen[15:8] = b;
                csum      = csum + b;
                pos       = 0;
                stage_cnt = 0;
                phase     = (plen == 0) ? CHECK : PAYLOAD;
            end
            PAYLOAD: begin
                csum = csum + b;
                if (pos < {plen[15:2], 2'b00}) begin
                    case (pos[1:0])
                        2'd0, 2'd2: low_hold = b;
                        2'd1: if (stage_cnt < StageMax) stage_tof[stage_cnt] = {b, low_hold};
                        default: begin
                            if (stage_cnt < StageMax) begin
                                stage_peak[stage_cnt] = {b, low_hold};
                                stage_cnt++;
                            end
                        end
                    endcase
                end
                pos = pos + 1;
                if (pos >= plen) phase = CHECK;
            end
            default: begin
                if (~csum != b) begin
                    st = ST_CHECKSUM;
                end else if ((plen >> 2) > StageMax) begin
                    st = ST_OVERSIZE;
                end else begin
                    st = ST_GOOD;
                    for (int k = 0; k < stage_cnt; k++) push_pair(stage_tof[k], stage_peak[k]);
                end
                phase = SEEK_A;
                pos   = 0;
                report_q = {report_q, window_report(st)};
            end
        endcase
    endtask

    task automatic compare_result();
        report_t want;
        if (report_q.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: result with nothing expected: dist %0d peak %0d st %0d cnt %0d",
                         $realtime, m_distance, m_avg_peak, m_frame_status, m_window_count);
            return;
        end
        want = report_q.pop_front();
        if (want.distance != m_distance || want.avg_peak != m_avg_peak ||
            want.status != m_frame_status || want.count != m_window_count) begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: mismatch exp dist %0d peak %0d st %0d cnt %0d, got %0d %0d %0d %0d",
                         $realtime, want.distance, want.avg_peak, want.status, want.count,
                         m_distance, m_avg_peak, m_frame_status, m_window_count);
        end
    endtask

    initial begin
        fail_count = 0;
        awaiting   = 0;
    end

    // Track all three channels on each edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            win_len   = 7'd1;
            offset    = 16'd0;
            gain      = 16'd256;
            phase     = SEEK_A;
            pos       = 0;
            plen      = 0;
            csum      = 0;
            low_hold  = 0;
            stage_cnt = 0;
            head      = 0;
            fill      = 0;
            report_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_WINDOW_LEN: begin
                        win_len = cfg_data[6:0];
                        head    = 0;
                        fill    = 0;
                    end
                    REG_OFFSET: offset = cfg_data;
                    REG_GAIN:   gain   = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) take_byte(s_rx_byte);
            if (m_valid && m_ready) compare_result();
        end
        awaiting = report_q.size();
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import tfda_pkg::*;

    localparam int WatchdogLimit = 20000;
    localparam int HoldCycles    = 800;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [23:0] m_distance;
    logic [15:0] m_avg_peak;
    logic [1:0]  m_frame_status;
    logic [6:0]  m_window_count;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_WINDOW_LEN;
    logic [15:0] cfg_data = 16'h0000;

    int fail_count, awaiting;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int bytes_sent = 0;
    int hold_left = 0;
    bit hold_toggle = 1'b0;
    bit hold_seen = 1'b0;
    int quiet_cycles = 0;

    tof_frame_deframer_averager dut (.*);

    frame_checker chk (.*);

    always #6 aclk = ~aclk;

    // Drive receiver readiness: random stalls plus a long hold on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_toggle != hold_seen) begin
            hold_seen <= hold_toggle;
            hold_left <= HoldCycles;
            m_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // End the run when nothing moves for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    // Send one frame; fill selects payload: 0 random, 1 all ones, 2 all zeros.
    task automatic send_frame(input int len, input int fill, input bit corrupt);
        logic [7:0] sum, b;
        sum = SYNC_B + len[7:0] + len[15:8];
        send_byte(SYNC_A);
        send_byte(SYNC_B);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        for (int i = 0; i < len; i++) begin
            case (fill)
                1: b = 8'hFF;
                2: b = 8'h00;
                default: b = 8'($urandom);
            endcase
            sum = sum + b;
            send_byte(b);
        end
        b = ~sum;
        if (corrupt) b = b ^ 8'($urandom_range(255, 1));
        send_byte(b);
    endtask

    // Noise that never holds the first sync byte, so it cannot open a frame.
    task automatic send_noise(input int n);
        logic [7:0] b;
        for (int i = 0; i < n; i++) begin
            b = 8'($urandom);
            if (b == SYNC_A) b = 8'hA5;
            send_byte(b);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Wait for the block to drain before touching registers.
    task automatic settle();
        s_valid <= 1'b0;
        wait (awaiting == 0);
        repeat (200) @(posedge aclk);
    endtask

    task automatic random_frames(input int byte_goal);
        int target, len;
        target = bytes_sent + byte_goal;
        while (bytes_sent < target) begin
            if ($urandom_range(99) < 20) send_noise($urandom_range(3));
            if ($urandom_range(99) < 80) begin
                len = $urandom_range(24);
            end else begin
                len = $urandom_range(72, 25);
            end
            if ($urandom_range(99) < 8) begin
                // truncated frame: header and a few bytes, then a fresh frame
                send_byte(SYNC_A);
                send_byte(SYNC_B);
                send_byte(8'($urandom_range(8, 1)));
                send_byte(8'h00);
                send_noise($urandom_range(2));
            end
            send_frame(len, $urandom_range(99) < 5 ? 1 : 0, $urandom_range(99) < 15);
        end
    endtask

    initial begin
        logic [15:0] wl [6];
        logic [15:0] off [6];
        logic [15:0] gn [6];
        wl  = '{16'd64, 16'd0, 16'd127, 16'd8, 16'd1, 16'h0183};
        off = '{16'd0, 16'd65535, 16'd100, 16'd1000, 16'd30000, 16'd0};
        gn  = '{16'd65535, 16'd0, 16'd512, 16'd300, 16'd256, 16'd1};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed frames with reset register values
        send_byte(8'h00);
        send_byte(SYNC_A);
        send_byte(SYNC_A);
        send_byte(8'h07);
        send_byte(SYNC_A);
        send_byte(SYNC_A);
        s_valid <= 1'b0;
        send_frame(0, 0, 1'b0);
        send_frame(4, 1, 1'b0);
        send_frame(6, 2, 1'b0);
        send_frame(4, 0, 1'b1);
        send_frame(260, 0, 1'b0);
        send_frame(7, 0, 1'b0);
        settle();

        for (int p = 0; p < 6; p++) begin
            write_reg(REG_WINDOW_LEN, wl[p]);
            write_reg(REG_OFFSET, p == 5 ? 16'($urandom) : off[p]);
            write_reg(REG_GAIN, p == 5 ? 16'($urandom) : gn[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            // a full staging buffer fills the widest window in one frame
            if (p == 0) send_frame(256, 0, 1'b0);
            if (p == 1) begin
                // long receiver hold while frames keep coming
                send_idle_pct = 0;
                hold_toggle = ~hold_toggle;
                for (int f = 0; f < 4; f++) send_frame($urandom_range(8), 0, 1'b0);
                send_idle_pct = 51;
            end
            random_frames(12);
            // pause the sender until every result is back
            s_valid <= 1'b0;
            wait (awaiting == 0);
            random_frames(12);
            settle();
        end

        if (fail_count == 0 && awaiting == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
